FILE: design/rosf_pkg.sv
// ----------------------------------------------------------------------------
// rosf_pkg
// Shared constants, register indexes and beat types for the rod obstacle
// screened force block.
// ----------------------------------------------------------------------------
package rosf_pkg;

  // Fixed point format of coordinates and forces.
  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int ACC_F_W   = 48;
  localparam int ACC_T_W   = 64;
  localparam int CFG_IDX_W = 3;

  // Default queue depths on either side of the force engine.
  localparam int IN_QUEUE_DEPTH  = 2;
  localparam int OUT_QUEUE_DEPTH = 2;

  // Highest power of t in the Taylor series of exp(-t).
  localparam int EXP_TERMS = 12;

  // log2(e) and ln(2) in Q30.
  localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [63:0] ONE_Q30   = 64'd1 << 30;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DIAMETER  = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [31:0] STRENGTH_RST     = 32'd65536;
  localparam logic [30:0] RADIUS_RST       = 31'd655360;
  localparam logic [31:0] CENTER_RST       = 32'd0;
  localparam logic [30:0] CUTOFF_RST       = 31'd196608;
  localparam logic [30:0] INV_DIAMETER_RST = 31'd65536;

  // Segment geometry prepared by the front end.
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic [30:0] axs;
    logic [30:0] ays;
    logic [1:0]  sh;
    logic [32:0] lever_x_mag;
    logic        lever_x_neg;
    logic [32:0] lever_y_mag;
    logic        lever_y_neg;
    logic        last;
  } seg_geom_t;

  // One result beat.
  typedef struct packed {
    logic signed [COORD_W-1:0] seg_force_x;
    logic signed [COORD_W-1:0] seg_force_y;
    logic signed [COORD_W-1:0] total_force_x;
    logic signed [COORD_W-1:0] total_force_y;
    logic signed [COORD_W-1:0] total_torque;
    logic                      rod_done;
    logic                      overlap_flag;
    logic                      saturated_flag;
  } seg_result_t;

  // Force law settings used by the back end.
  typedef struct packed {
    logic [31:0] strength;
    logic [30:0] obstacle_radius;
    logic [30:0] cutoff_range;
    logic [30:0] inverse_segment_diameter;
  } force_cfg_t;

  // Request to and response from the shared multiply-divide unit.
  typedef struct packed {
    logic        start;
    logic        shift_mode;
    logic [4:0]  sh;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } md_rsp_t;

endpackage

FILE: design/rod_obstacle_screened_force.sv
// ----------------------------------------------------------------------------
// rod_obstacle_screened_force
// Screened exponential repulsion of rod segments from a circular obstacle,
// with per-rod force and torque totals.
// ----------------------------------------------------------------------------
// One segment is taken per beat and gives one result beat. The front end
// queues the segment's geometry at once; the force engine then works through
// the segment on one shared 64-bit multiply-divide unit. A segment that
// overlaps the obstacle or lies beyond the cutoff runs no divider pass; one
// inside the active shell runs up to sixteen divider passes of that unit.
// Queues of two beats on each side let the caller keep pushing and popping
// while a segment is worked on. Configuration registers are written one a
// cycle on the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module rod_obstacle_screened_force #(
  parameter int IN_DEPTH  = rosf_pkg::IN_QUEUE_DEPTH,
  parameter int OUT_DEPTH = rosf_pkg::OUT_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [rosf_pkg::COORD_W-1:0] seg_x_pos,
  input  logic signed [rosf_pkg::COORD_W-1:0] seg_y_pos,
  input  logic signed [rosf_pkg::COORD_W-1:0] mass_center_x,
  input  logic signed [rosf_pkg::COORD_W-1:0] mass_center_y,
  input  logic                                last_of_rod,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [rosf_pkg::COORD_W-1:0] seg_force_x,
  output logic signed [rosf_pkg::COORD_W-1:0] seg_force_y,
  output logic signed [rosf_pkg::COORD_W-1:0] total_force_x,
  output logic signed [rosf_pkg::COORD_W-1:0] total_force_y,
  output logic signed [rosf_pkg::COORD_W-1:0] total_torque,
  output logic                                rod_done,
  output logic                                overlap_flag,
  output logic                                saturated_flag,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rosf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);

  import rosf_pkg::*;

  logic [31:0] circle_center_x;
  logic [31:0] circle_center_y;
  force_cfg_t  cfg;
  logic        geom_valid;
  logic        geom_pop;
  seg_geom_t   geom;
  logic        res_full;
  logic        res_push;
  seg_result_t res_data;
  seg_result_t res_head;

  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strength                 <= STRENGTH_RST;
      cfg.obstacle_radius          <= RADIUS_RST;
      circle_center_x              <= CENTER_RST;
      circle_center_y              <= CENTER_RST;
      cfg.cutoff_range             <= CUTOFF_RST;
      cfg.inverse_segment_diameter <= INV_DIAMETER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STRENGTH:     cfg.strength                 <= cfg_data;
        REG_RADIUS:       cfg.obstacle_radius          <= cfg_data[30:0];
        REG_CENTER_X:     circle_center_x              <= cfg_data;
        REG_CENTER_Y:     circle_center_y              <= cfg_data;
        REG_CUTOFF:       cfg.cutoff_range             <= cfg_data[30:0];
        REG_INV_DIAMETER: cfg.inverse_segment_diameter <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: geometry and input queue.
  rosf_front #(
    .DEPTH(IN_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .seg_x_pos      (seg_x_pos),
    .seg_y_pos      (seg_y_pos),
    .mass_center_x  (mass_center_x),
    .mass_center_y  (mass_center_y),
    .last_of_rod    (last_of_rod),
    .circle_center_x(circle_center_x),
    .circle_center_y(circle_center_y),
    .geom_valid     (geom_valid),
    .geom_pop       (geom_pop),
    .geom           (geom)
  );

  // Force engine.
  rosf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .geom_valid(geom_valid),
    .geom_pop  (geom_pop),
    .geom      (geom),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // Result queue.
  rosf_queue #(
    .WIDTH($bits(seg_result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_data),
    .full (res_full),
    .pop  (pop),
    .rdata(res_head),
    .empty(empty)
  );

  assign seg_force_x    = res_head.seg_force_x;
  assign seg_force_y    = res_head.seg_force_y;
  assign total_force_x  = res_head.total_force_x;
  assign total_force_y  = res_head.total_force_y;
  assign total_torque   = res_head.total_torque;
  assign rod_done       = res_head.rod_done;
  assign overlap_flag   = res_head.overlap_flag;
  assign saturated_flag = res_head.saturated_flag;

endmodule

FILE: design/rosf_queue.sv
// ----------------------------------------------------------------------------
// rosf_queue
// Small first-in first-out queue of register entries.
// ----------------------------------------------------------------------------
module rosf_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/rosf_front.sv
// ----------------------------------------------------------------------------
// rosf_front
// Accepts segment beats, works out the offset from the obstacle centre and
// the lever about the centre of mass, and queues the geometry.
// ----------------------------------------------------------------------------
module rosf_front #(
  parameter int DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [rosf_pkg::COORD_W-1:0] seg_x_pos,
  input  logic signed [rosf_pkg::COORD_W-1:0] seg_y_pos,
  input  logic signed [rosf_pkg::COORD_W-1:0] mass_center_x,
  input  logic signed [rosf_pkg::COORD_W-1:0] mass_center_y,
  input  logic                              last_of_rod,
  input  logic [31:0]                       circle_center_x,
  input  logic [31:0]                       circle_center_y,
  output logic                              geom_valid,
  input  logic                              geom_pop,
  output rosf_pkg::seg_geom_t               geom
);

  import rosf_pkg::*;

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [32:0] lx;
  logic signed [32:0] ly;
  logic [32:0]        ax;
  logic [32:0]        ay;
  logic [32:0]        big;
  logic [1:0]         sh;
  seg_geom_t          geom_in;
  logic               geom_empty;

  // Offsets, magnitudes and the scaling shift that keeps both below 2^31.
  always_comb begin
    dx  = 33'(seg_x_pos) - 33'($signed(circle_center_x));
    dy  = 33'(seg_y_pos) - 33'($signed(circle_center_y));
    lx  = 33'(seg_x_pos) - 33'(mass_center_x);
    ly  = 33'(seg_y_pos) - 33'(mass_center_y);
    ax  = dx[32] ? 33'(-dx) : 33'(dx);
    ay  = dy[32] ? 33'(-dy) : 33'(dy);
    big = (ax > ay) ? ax : ay;
    if (big[32]) begin
      sh = 2'd2;
    end else if (big[31]) begin
      sh = 2'd1;
    end else begin
      sh = 2'd0;
    end
    geom_in.neg_x       = dx[32];
    geom_in.neg_y       = dy[32];
    geom_in.axs         = 31'(ax >> sh);
    geom_in.ays         = 31'(ay >> sh);
    geom_in.sh          = sh;
    geom_in.lever_x_mag = lx[32] ? 33'(-lx) : 33'(lx);
    geom_in.lever_x_neg = lx[32];
    geom_in.lever_y_mag = ly[32] ? 33'(-ly) : 33'(ly);
    geom_in.lever_y_neg = ly[32];
    geom_in.last        = last_of_rod;
  end

  // Queue towards the force engine.
  rosf_queue #(
    .WIDTH($bits(seg_geom_t)),
    .DEPTH(DEPTH)
  ) u_geom_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(geom_in),
    .full (full),
    .pop  (geom_pop),
    .rdata(geom),
    .empty(geom_empty)
  );

  assign geom_valid = !geom_empty;

endmodule

FILE: design/rosf_muldiv.sv
// ----------------------------------------------------------------------------
// rosf_muldiv
// Shared unit for floor(a*b/c) on 64-bit operands, saturating to all ones.
// The product is built from four 32x32 partial products; the quotient comes
// either from a right shift or from a restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
module rosf_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  rosf_pkg::md_req_t req,
  output rosf_pkg::md_rsp_t rsp
);

  import rosf_pkg::*;

  typedef enum logic [1:0] {
    M_IDLE,
    M_MUL,
    M_CHK,
    M_DIV
  } md_state_t;

  md_state_t    state;
  logic [63:0]  op_a;
  logic [63:0]  op_b;
  logic [63:0]  op_c;
  logic [4:0]   op_sh;
  logic         op_shift;
  logic [127:0] prod;
  logic [63:0]  pp;
  logic [1:0]   pp_pos;
  logic [2:0]   mul_cnt;
  logic [5:0]   div_cnt;
  logic [63:0]  rem;
  logic [63:0]  lo;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [127:0] shifted;
  logic [64:0]  rem_sh;
  logic         q_bit;

  // Operand halves for the current partial product.
  always_comb begin
    a_part  = mul_cnt[1] ? op_a[63:32] : op_a[31:0];
    b_part  = mul_cnt[0] ? op_b[63:32] : op_b[31:0];
    shifted = prod >> op_sh;
    rem_sh  = {rem, lo[63]};
    q_bit   = (rem_sh >= {1'b0, op_c});
  end

  // Sequencer, product accumulation and division.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= M_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (req.start) begin
            op_a     <= req.a;
            op_b     <= req.b;
            op_c     <= req.c;
            op_sh    <= req.sh;
            op_shift <= req.shift_mode;
            prod     <= '0;
            mul_cnt  <= '0;
            state    <= M_MUL;
          end
        end
        M_MUL: begin
          if (mul_cnt != 3'd4) begin
            pp     <= a_part * b_part;
            pp_pos <= {1'b0, mul_cnt[1]} + {1'b0, mul_cnt[0]};
          end
          if (mul_cnt != 3'd0) begin
            prod <= prod + ({64'd0, pp} << (7'd32 * pp_pos));
          end
          if (mul_cnt == 3'd4) begin
            state <= M_CHK;
          end
          mul_cnt <= mul_cnt + 1'b1;
        end
        M_CHK: begin
          if (op_shift) begin
            rsp.quo  <= (shifted[127:64] != '0) ? '1 : shifted[63:0];
            rsp.done <= 1'b1;
            state    <= M_IDLE;
          end else if (op_c == '0 || prod[127:64] >= op_c) begin
            rsp.quo  <= '1;
            rsp.done <= 1'b1;
            state    <= M_IDLE;
          end else begin
            rem     <= prod[127:64];
            lo      <= prod[63:0];
            div_cnt <= '0;
            state   <= M_DIV;
          end
        end
        M_DIV: begin
          // The low word shifts out dividend bits and shifts in quotient bits.
          rem <= q_bit ? 64'(rem_sh - {1'b0, op_c}) : rem_sh[63:0];
          lo  <= {lo[62:0], q_bit};
          if (div_cnt == 6'd63) begin
            rsp.quo  <= {lo[62:0], q_bit};
            rsp.done <= 1'b1;
            state    <= M_IDLE;
          end
          div_cnt <= div_cnt + 1'b1;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/rosf_back.sv
// ----------------------------------------------------------------------------
// rosf_back
// Force engine: takes queued segment geometry, evaluates the screened
// exponential law step by step on the shared multiply-divide unit, forms the
// torque, updates the rod accumulators and pushes one result beat.
// ----------------------------------------------------------------------------
module rosf_back (
  input  logic                   clk,
  input  logic                   rst,
  input  rosf_pkg::force_cfg_t   cfg,
  input  logic                   geom_valid,
  output logic                   geom_pop,
  input  rosf_pkg::seg_geom_t    geom,
  input  logic                   res_full,
  output logic                   res_push,
  output rosf_pkg::seg_result_t  res_data
);

  import rosf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_CLASS,
    ST_RECIP,
    ST_XEXP,
    ST_YEXP,
    ST_T,
    ST_TERM,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_UX,
    ST_MX,
    ST_UY,
    ST_MY,
    ST_FORCE,
    ST_TQX,
    ST_TQY,
    ST_ACC
  } back_state_t;

  back_state_t        state;
  logic               waiting;
  seg_geom_t          g;
  logic [63:0]        sumsq;
  logic [63:0]        sq_v;
  logic [63:0]        sq_res;
  logic [63:0]        sq_bit;
  logic [4:0]         sq_cnt;
  logic [31:0]        rs;
  logic [30:0]        du;
  logic [63:0]        a_val;
  logic [63:0]        x_val;
  logic [63:0]        y_val;
  logic [5:0]         m_sh;
  logic [63:0]        t_val;
  logic [63:0]        term;
  logic signed [32:0] esum;
  logic [3:0]         n_idx;
  logic [63:0]        p_val;
  logic [63:0]        ux;
  logic [63:0]        magx;
  logic [63:0]        magy;
  logic               ovl;
  logic [31:0]        fx;
  logic [31:0]        fy;
  logic               fsat;
  logic signed [63:0] tp1;
  logic signed [63:0] tp2;
  logic               tclip;
  logic signed [47:0] acc_force_x;
  logic signed [47:0] acc_force_y;
  logic signed [63:0] acc_torque;
  logic               acc_saturated;

  md_req_t            req;
  md_rsp_t            rsp;
  logic               op_state;
  logic               md_done;

  logic [63:0]        sq_sum;
  logic [63:0]        sq_v_next;
  logic [63:0]        sq_res_next;
  logic [33:0]        r_full;
  logic signed [35:0] surf_dist;
  logic [32:0]        fx_sf;
  logic [32:0]        fy_sf;
  logic [32:0]        fx_mag;
  logic [32:0]        fy_mag;
  logic [64:0]        tq_part;

  logic signed [48:0] sum_fx;
  logic signed [48:0] sum_fy;
  logic signed [47:0] new_fx;
  logic signed [47:0] new_fy;
  logic               clip_fx;
  logic               clip_fy;
  logic signed [63:0] tq_term;
  logic signed [64:0] sum_tq;
  logic signed [63:0] new_tq;
  logic               clip_tq;
  logic               new_sat;
  logic [32:0]        tot_x;
  logic [32:0]        tot_y;
  logic [32:0]        tot_t;
  logic               done_sat;

  // Signed, clipped force component from a magnitude and a direction.
  function automatic logic [32:0] sat_force(input logic [63:0] m, input logic neg);
    logic        s;
    logic [31:0] v;
    s = 1'b0;
    if (neg) begin
      if (m > 64'h8000_0000) begin
        s = 1'b1;
        v = 32'h8000_0000;
      end else begin
        v = 32'(-m);
      end
    end else begin
      if (m >= 64'h8000_0000) begin
        s = 1'b1;
        v = 32'h7fff_ffff;
      end else begin
        v = m[31:0];
      end
    end
    return {s, v};
  endfunction

  // One torque product with its magnitude clipped to 2^62-1.
  function automatic logic [64:0] torque_part(input logic [63:0] m, input logic neg);
    logic        c;
    logic [63:0] v;
    c = (m > 64'h3fff_ffff_ffff_ffff);
    v = c ? 64'h3fff_ffff_ffff_ffff : m;
    return {c, neg ? 64'(-v) : v};
  endfunction

  // Clip a 64-bit signed value to the 32-bit range.
  function automatic logic [32:0] clip32(input logic signed [63:0] v);
    logic c;
    logic [31:0] r;
    c = 1'b0;
    if (v > 64'sh7fff_ffff) begin
      c = 1'b1;
      r = 32'h7fff_ffff;
    end else if (v < -64'sh8000_0000) begin
      c = 1'b1;
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return {c, r};
  endfunction

  // Integer square root step, distance and force shaping.
  always_comb begin
    sq_sum = sq_res + sq_bit;
    if (sq_v >= sq_sum) begin
      sq_v_next   = sq_v - sq_sum;
      sq_res_next = (sq_res >> 1) + sq_bit;
    end else begin
      sq_v_next   = sq_v;
      sq_res_next = sq_res >> 1;
    end
    r_full    = {2'b00, rs} << g.sh;
    surf_dist = $signed({2'b00, r_full}) - $signed({5'b0, cfg.obstacle_radius});
    fx_sf  = sat_force(magx, g.neg_x);
    fy_sf  = sat_force(magy, g.neg_y);
    fx_mag = fx[31] ? 33'(-$signed({fx[31], fx})) : {1'b0, fx};
    fy_mag = fy[31] ? 33'(-$signed({fy[31], fy})) : {1'b0, fy};
    tq_part = torque_part(rsp.quo, (state == ST_TQX) ? (g.lever_x_neg != fy[31])
                                                     : (g.lever_y_neg != fx[31]));
  end

  // Operand selection for the multiply-divide unit.
  always_comb begin
    req      = '0;
    op_state = 1'b1;
    case (state)
      ST_SQX: begin
        req.shift_mode = 1'b1;
        req.a = {33'd0, g.axs};
        req.b = {33'd0, g.axs};
      end
      ST_SQY: begin
        req.shift_mode = 1'b1;
        req.a = {33'd0, g.ays};
        req.b = {33'd0, g.ays};
      end
      ST_RECIP: begin
        req.a = 64'd1 << (2 * FRAC_W - 1);
        req.b = 64'd1;
        req.c = {33'd0, du};
      end
      ST_XEXP: begin
        req.shift_mode = 1'b1;
        req.sh = 5'(FRAC_W - 1);
        req.a = {33'd0, du};
        req.b = {33'd0, cfg.inverse_segment_diameter};
      end
      ST_YEXP: begin
        req.shift_mode = 1'b1;
        req.sh = 5'(FRAC_W);
        req.a = x_val;
        req.b = LOG2E_Q30;
      end
      ST_T: begin
        req.shift_mode = 1'b1;
        req.sh = 5'd30;
        req.a = {34'd0, y_val[29:0]};
        req.b = LN2_Q30;
      end
      ST_TERM: begin
        req.a = term;
        req.b = t_val;
        req.c = 64'(n_idx) << 30;
      end
      ST_P1: begin
        req.shift_mode = 1'b1;
        req.sh = 5'(FRAC_W);
        req.a = {32'd0, cfg.strength};
        req.b = a_val;
      end
      ST_P2: begin
        req.shift_mode = 1'b1;
        req.sh = 5'd30;
        req.a = p_val;
        req.b = (esum > 0) ? {31'd0, esum} : 64'd0;
      end
      ST_P3: begin
        req.a = p_val;
        req.b = 64'd1 << FRAC_W;
        req.c = {33'd0, du};
      end
      ST_UX: begin
        req.a = {33'd0, g.axs};
        req.b = ONE_Q30;
        req.c = {32'd0, rs};
      end
      ST_UY: begin
        req.a = {33'd0, g.ays};
        req.b = ONE_Q30;
        req.c = {32'd0, rs};
      end
      ST_MX, ST_MY: begin
        req.shift_mode = 1'b1;
        req.sh = 5'd30;
        req.a = p_val;
        req.b = ux;
      end
      ST_TQX: begin
        req.shift_mode = 1'b1;
        req.sh = 5'(FRAC_W);
        req.a = {31'd0, g.lever_x_mag};
        req.b = {31'd0, fy_mag};
      end
      ST_TQY: begin
        req.shift_mode = 1'b1;
        req.sh = 5'(FRAC_W);
        req.a = {31'd0, g.lever_y_mag};
        req.b = {31'd0, fx_mag};
      end
      default: begin
        op_state = 1'b0;
      end
    endcase
    req.start = op_state && !waiting;
  end

  assign md_done = waiting && rsp.done;

  rosf_muldiv u_muldiv (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Accumulator update and result assembly.
  always_comb begin
    sum_fx  = 49'(acc_force_x) + 49'($signed(fx));
    sum_fy  = 49'(acc_force_y) + 49'($signed(fy));
    clip_fx = (sum_fx[48] != sum_fx[47]);
    clip_fy = (sum_fy[48] != sum_fy[47]);
    new_fx  = clip_fx ? {sum_fx[48], {47{!sum_fx[48]}}} : sum_fx[47:0];
    new_fy  = clip_fy ? {sum_fy[48], {47{!sum_fy[48]}}} : sum_fy[47:0];
    tq_term = tp1 - tp2;
    sum_tq  = 65'(acc_torque) + 65'(tq_term);
    clip_tq = (sum_tq[64] != sum_tq[63]);
    new_tq  = clip_tq ? {sum_tq[64], {63{!sum_tq[64]}}} : sum_tq[63:0];
    new_sat = acc_saturated || clip_fx || clip_fy || clip_tq || tclip;
    tot_x   = clip32(64'(new_fx));
    tot_y   = clip32(64'(new_fy));
    tot_t   = clip32(new_tq);
    done_sat = tot_x[32] || tot_y[32] || tot_t[32] || new_sat;

    res_data.seg_force_x    = fx;
    res_data.seg_force_y    = fy;
    res_data.total_force_x  = g.last ? tot_x[31:0] : '0;
    res_data.total_force_y  = g.last ? tot_y[31:0] : '0;
    res_data.total_torque   = g.last ? tot_t[31:0] : '0;
    res_data.rod_done       = g.last;
    res_data.overlap_flag   = ovl;
    res_data.saturated_flag = fsat || (g.last && done_sat);
  end

  assign geom_pop = (state == ST_IDLE) && geom_valid;
  assign res_push = (state == ST_ACC) && !res_full;

  // Step sequencer and per-segment registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      waiting       <= 1'b0;
      acc_force_x   <= '0;
      acc_force_y   <= '0;
      acc_torque    <= '0;
      acc_saturated <= 1'b0;
    end else begin
      if (req.start) begin
        waiting <= 1'b1;
      end else if (md_done) begin
        waiting <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (geom_valid) begin
            g     <= geom;
            ovl   <= 1'b0;
            magx  <= '0;
            magy  <= '0;
            state <= ST_SQX;
          end
        end
        ST_SQX: begin
          if (md_done) begin
            sumsq <= rsp.quo;
            state <= ST_SQY;
          end
        end
        ST_SQY: begin
          if (md_done) begin
            sq_v   <= sumsq + rsp.quo;
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            sq_cnt <= '0;
            state  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          sq_v   <= sq_v_next;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 5'd31) begin
            rs    <= sq_res_next[31:0];
            state <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          // Overlap, beyond cutoff, or inside the active shell.
          if (surf_dist <= 0) begin
            ovl   <= 1'b1;
            state <= ST_FORCE;
          end else if (surf_dist > $signed({5'b0, cfg.cutoff_range})) begin
            state <= ST_FORCE;
          end else begin
            du    <= surf_dist[30:0];
            state <= ST_RECIP;
          end
        end
        ST_RECIP: begin
          if (md_done) begin
            a_val <= {33'd0, cfg.inverse_segment_diameter} + rsp.quo;
            state <= ST_XEXP;
          end
        end
        ST_XEXP: begin
          if (md_done) begin
            x_val <= rsp.quo;
            state <= ST_YEXP;
          end
        end
        ST_YEXP: begin
          if (md_done) begin
            y_val <= rsp.quo;
            // A power of two of 64 or more wipes the force out.
            if (rsp.quo[63:36] != '0) begin
              state <= ST_FORCE;
            end else begin
              m_sh  <= rsp.quo[35:30];
              state <= ST_T;
            end
          end
        end
        ST_T: begin
          if (md_done) begin
            t_val <= rsp.quo;
            term  <= ONE_Q30;
            esum  <= 33'(ONE_Q30);
            n_idx <= 4'd1;
            state <= ST_TERM;
          end
        end
        ST_TERM: begin
          if (md_done) begin
            term  <= rsp.quo;
            esum  <= n_idx[0] ? esum - $signed(33'(rsp.quo))
                              : esum + $signed(33'(rsp.quo));
            n_idx <= n_idx + 1'b1;
            if (n_idx == 4'(EXP_TERMS)) begin
              state <= ST_P1;
            end
          end
        end
        ST_P1: begin
          if (md_done) begin
            p_val <= rsp.quo;
            state <= ST_P2;
          end
        end
        ST_P2: begin
          if (md_done) begin
            p_val <= rsp.quo;
            state <= ST_P3;
          end
        end
        ST_P3: begin
          if (md_done) begin
            p_val <= rsp.quo;
            state <= ST_UX;
          end
        end
        ST_UX: begin
          if (md_done) begin
            ux    <= rsp.quo;
            state <= ST_MX;
          end
        end
        ST_MX: begin
          if (md_done) begin
            magx  <= rsp.quo >> m_sh;
            state <= ST_UY;
          end
        end
        ST_UY: begin
          if (md_done) begin
            ux    <= rsp.quo;
            state <= ST_MY;
          end
        end
        ST_MY: begin
          if (md_done) begin
            magy  <= rsp.quo >> m_sh;
            state <= ST_FORCE;
          end
        end
        ST_FORCE: begin
          fx    <= fx_sf[31:0];
          fy    <= fy_sf[31:0];
          fsat  <= fx_sf[32] || fy_sf[32];
          state <= ST_TQX;
        end
        ST_TQX: begin
          if (md_done) begin
            tp1   <= $signed(tq_part[63:0]);
            tclip <= tq_part[64];
            state <= ST_TQY;
          end
        end
        ST_TQY: begin
          if (md_done) begin
            tp2   <= $signed(tq_part[63:0]);
            tclip <= tclip || tq_part[64];
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (!res_full) begin
            if (g.last) begin
              acc_force_x   <= '0;
              acc_force_y   <= '0;
              acc_torque    <= '0;
              acc_saturated <= 1'b0;
            end else begin
              acc_force_x   <= new_fx;
              acc_force_y   <= new_fy;
              acc_torque    <= new_tq;
              acc_saturated <= new_sat;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/rosf_checker.sv
// ----------------------------------------------------------------------------
// rosf_checker
// Port-level checks for the rod obstacle screened force block, bound to the
// top level.
// ----------------------------------------------------------------------------
module rosf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic signed [rosf_pkg::COORD_W-1:0] seg_force_x,
  input logic signed [rosf_pkg::COORD_W-1:0] seg_force_y,
  input logic signed [rosf_pkg::COORD_W-1:0] total_force_x,
  input logic signed [rosf_pkg::COORD_W-1:0] total_force_y,
  input logic signed [rosf_pkg::COORD_W-1:0] total_torque,
  input logic                                rod_done
,
  input logic                                overlap_flag
);

  // Totals are only shown on the last segment of a rod.
  a_totals_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !rod_done |-> total_force_x == 0 && total_force_y == 0 && total_torque == 0)
    else $error("rod totals shown on a segment that is not the last");

  // A segment touching the obstacle receives no force.
  a_overlap_no_force: assert property (@(posedge clk) disable iff (rst)
    !empty && overlap_flag |-> seg_force_x == 0 && seg_force_y == 0)
    else $error("force reported on an overlapping segment");

  // Reset leaves the result queue empty and the input queue not full.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not empty after reset");

  // A result beat that is not taken stays as it is.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(seg_force_x) && $stable(rod_done))
    else $error("waiting result beat changed");

endmodule

bind rod_obstacle_screened_force rosf_checker u_rosf_checker (.*);
